// File: hdl/cbmt_pkg.sv
// ----------------------------------------------------------------------------
// cbmt_pkg
// Shared types and constants for the counter bank with max tracking.
// ----------------------------------------------------------------------------
package cbmt_pkg;

	localparam int NUM_COUNTERS = 16;
	localparam int CNT_W        = 16;
	localparam int IDX_W        = 4;
	localparam int NUM_W        = 5;

	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_INC = 2'd0,
		OP_DEC = 2'd1,
		OP_CLR = 2'd2,
		OP_QRY = 2'd3
	} op_t;

	typedef struct packed {
		op_t              opcode;
		logic [IDX_W-1:0] counter_index;
	} in_word_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] counter_value;
		logic signed [CNT_W-1:0] max_value;
		logic [NUM_W-1:0]        num_at_max;
	} out_word_t;

	// update strobe for one cell
	typedef struct packed {
		logic upd;
		op_t  op;
	} cell_ctrl_t;

	// running max / count passed cell to cell
	typedef struct packed {
		logic                    vld;
		logic                    first;
		logic signed [CNT_W-1:0] max;
		logic [NUM_W-1:0]        cnt;
	} sweep_t;

endpackage

// File: hdl/cbmt_cell.sv
// ----------------------------------------------------------------------------
// cbmt_cell
// One counter with saturating update and one stage of the max/count sweep.
// ----------------------------------------------------------------------------
module cbmt_cell
	import cbmt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctrl_t              ctrl,
	input  sweep_t                  sweep_in,
	output logic signed [CNT_W-1:0] value,
	output sweep_t                  sweep_out
);

	logic signed [CNT_W-1:0] cnt_q;
	logic signed [CNT_W-1:0] cnt_nxt;
	sweep_t                  sweep_nxt;
	sweep_t                  sweep_q;

	always_comb begin
		cnt_nxt = cnt_q;
		case (ctrl.op)
			OP_INC: begin
				if (cnt_q != CNT_MAX) cnt_nxt = cnt_q + CNT_W'(1);
			end
			OP_DEC: begin
				if (cnt_q != CNT_MIN) cnt_nxt = cnt_q - CNT_W'(1);
			end
			OP_CLR: begin
				cnt_nxt = '0;
			end
			default: begin
				cnt_nxt = cnt_q;
			end
		endcase
	end

	always_comb begin
		sweep_nxt       = sweep_in;
		sweep_nxt.first = 1'b0;
		if (sweep_in.first || (cnt_q > sweep_in.max)) begin
			sweep_nxt.max = cnt_q;
			sweep_nxt.cnt = NUM_W'(1);
		end else if (cnt_q == sweep_in.max) begin
			// count saturates at the field's top
			if (sweep_in.cnt != {NUM_W{1'b1}}) sweep_nxt.cnt = sweep_in.cnt + NUM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sweep_q <= '0;
		end else begin
			if (ctrl.upd) cnt_q <= cnt_nxt;
			sweep_q <= sweep_nxt;
		end
	end

	assign value     = cnt_q;
	assign sweep_out = sweep_q;

endmodule

// File: hdl/counter_bank_max_tracker_top.sv
// ----------------------------------------------------------------------------
// counter_bank_max_tracker_top
// Bank of saturating signed counters; each word updates or queries one
// counter and reports its value, the bank maximum and how many hold it.
// ----------------------------------------------------------------------------
//
//  channel | signals                     | payload
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid / in_ready         | in_data  : opcode, counter_index
//  out     | out_valid / out_ready       | out_data : counter_value, max_value,
//          |                             |            num_at_max
//
// A word updates its counter at the accept edge; a sweep token then walks
// the row of cells, one cell per cycle, carrying the running max and count.
// The result passes start_q, the cell registers, res_q and the output
// register on its way to out_valid; the next word is taken once the sweep
// result has moved into the output register, so one word is in flight.
// While the output register is stalled, a finished sweep result waits in
// res_q and in_ready stays low until it moves on. Reset clears all counters.
//
module counter_bank_max_tracker_top
	import cbmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	logic                    busy_q;     // word in flight, result not yet in output reg
	logic                    start_q;    // launches the sweep at cell 0
	logic [IDX_W-1:0]        idx_q;
	logic signed [CNT_W-1:0] named_q;
	logic                    res_vld_q;
	out_word_t               res_q;
	logic                    out_valid_q;
	out_word_t               out_q;

	logic                    in_acc;
	logic                    res_move;
	logic signed [CNT_W-1:0] named_sel;
	logic signed [CNT_W-1:0] cell_val [NUM_COUNTERS];
	sweep_t                  chain    [NUM_COUNTERS+1];
	cell_ctrl_t              ctrl     [NUM_COUNTERS];

	assign in_acc   = in_valid && in_ready;
	assign in_ready = !busy_q;
	// sweep result moves on when the output register is empty or being drained
	assign res_move = res_vld_q && (!out_valid_q || out_ready);

	// head of the chain: first cell seeds max/count with its own value
	always_comb begin
		chain[0]       = '0;
		chain[0].vld   = start_q;
		chain[0].first = 1'b1;
	end

	// row of cells; an index beyond the bank selects none
	for (genvar k = 0; k < NUM_COUNTERS; k++) begin : g_cell
		always_comb begin
			ctrl[k].upd = in_acc && (32'(in_data.counter_index) == k);
			ctrl[k].op  = in_data.opcode;
		end

		cbmt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[k]),
			.sweep_in  (chain[k]),
			.value     (cell_val[k]),
			.sweep_out (chain[k+1])
		);
	end

	// named counter readback, zero when out of the bank
	always_comb begin
		named_sel = '0;
		for (int k = 0; k < NUM_COUNTERS; k++) begin
			if (32'(idx_q) == k) named_sel = cell_val[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			res_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (res_move) begin
				busy_q <= 1'b0;
			end
			if (chain[NUM_COUNTERS].vld) begin
				res_vld_q <= 1'b1;
			end else if (res_move) begin
				res_vld_q <= 1'b0;
			end
			if (res_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) idx_q <= in_data.counter_index;
		if (start_q) named_q <= named_sel;
		if (chain[NUM_COUNTERS].vld) begin
			res_q.counter_value <= named_q;
			res_q.max_value     <= chain[NUM_COUNTERS].max;
			res_q.num_at_max    <= chain[NUM_COUNTERS].cnt;
		end
		if (res_move) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: sim/counter_bank_max_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// counter_bank_max_tracker_top_tb
// Self-checking bench for the counter bank with max tracking. A directed
// script covers every opcode, short ramps up and down, and a zero maximum
// among negative counters. Random traffic with gaps and output stalls
// follows. Every word is checked against a typed result or a local model of the bank.
// ----------------------------------------------------------------------------
module counter_bank_max_tracker_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbmt_pkg::*;

	// one script row: a word, how many times it is sent, and the result
	// typed in where it is obvious (otherwise the bank model decides)
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [16:0]      reps;
		logic             typed;
		out_word_t        want;
	} script_row_t;

	localparam int RANDOM_WORDS = 1850;
	localparam int MAX_PRINTS   = 50;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// typed expectation travels with the word on the input side
	logic      in_typed  = 1'b0;
	out_word_t in_want   = '0;

	// calm: no gaps on either side (ramps and some random stretches)
	bit        calm      = 1'b0;
	int        mismatch_count = 0;

	logic signed [CNT_W-1:0] bank [NUM_COUNTERS];
	out_word_t               pending_results [$];
	script_row_t             script [18];

	counter_bank_max_tracker_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Slowest legal run: about 1900 words plus worst gaps and stalls
	// (under 4 ms). Allow several times that.
	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// mostly back to back, often a short gap, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Bank model: apply one word, return the result it should produce.
	function automatic out_word_t apply_to_bank(in_word_t w);
		out_word_t               r;
		logic signed [CNT_W-1:0] v;
		logic signed [CNT_W-1:0] top;
		int                      hits;
		v = '0;
		if (w.counter_index < NUM_COUNTERS) begin
			v = bank[w.counter_index];
			case (w.opcode)
			OP_INC: begin
				if (v != CNT_MAX)
					v = v + 16'sd1;
			end
			OP_DEC: begin
				if (v != CNT_MIN)
					v = v - 16'sd1;
			end
			OP_CLR: begin
				v = '0;
			end
			default: begin
			end
			endcase
			bank[w.counter_index] = v;
		end
		top = bank[0];
		for (int k = 1; k < NUM_COUNTERS; k++)
			if (bank[k] > top)
				top = bank[k];
		hits = 0;
		for (int k = 0; k < NUM_COUNTERS; k++)
			if (bank[k] == top)
				hits++;
		if (hits > 31)
			hits = 31;
		r.counter_value = v;
		r.max_value     = top;
		r.num_at_max    = hits[NUM_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Present one word after an optional idle gap; valid holds until the
	// accepting edge. Returns right after that edge.
	task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
		int gap;
		gap = calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		in_typed <= typed;
		in_want  <= want;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Output back-pressure: random stall runs, none while calm.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (calm || hold == 0) begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(99) < 30)
					hold = pick_gap();
			end else begin
				out_ready <= 1'b0;
				hold--;
			end
		end
	end

	// Both channels sampled at the rising edge. An accepted input word runs
	// the bank model; an accepted output word is checked against the oldest
	// expectation.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && in_valid && in_ready) begin
			want = apply_to_bank(in_data);
			pending_results.insert(pending_results.size(), in_typed ? in_want : want);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("word with none expected: %0d %0d %0d",
					out_data.counter_value, out_data.max_value, out_data.num_at_max));
			end else begin
				want = pending_results.pop_front();
				if (out_data.counter_value !== want.counter_value)
					report_mismatch($sformatf("counter_value got %0d, expected %0d",
						out_data.counter_value, want.counter_value));
				if (out_data.max_value !== want.max_value)
					report_mismatch($sformatf("max_value got %0d, expected %0d",
						out_data.max_value, want.max_value));
				if (out_data.num_at_max !== want.num_at_max)
					report_mismatch($sformatf("num_at_max got %0d, expected %0d",
						out_data.num_at_max, want.num_at_max));
			end
		end
	end

	initial begin
		in_word_t w;
		int       sent;
		int       seg_len;
		int       r;

		foreach (bank[i])
			bank[i] = '0;

		// Directed script. Rows with reps > 1 are short back-to-back ramps;
		// their words are checked by the bank model.
		script = '{
			// fresh bank: all zero, all sixteen at the max
			'{OP_QRY, 4'd0,  17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd16}},
			'{OP_QRY, 4'd15, 17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd16}},
			'{OP_INC, 4'd0,  17'd1,     1'b1, '{16'sd1, 16'sd1, 5'd1}},
			'{OP_INC, 4'd15, 17'd1,     1'b1, '{16'sd1, 16'sd1, 5'd2}},
			'{OP_DEC, 4'd0,  17'd1,     1'b1, '{16'sd0, 16'sd1, 5'd1}},
			'{OP_DEC, 4'd7,  17'd1,     1'b1, '{-16'sd1, 16'sd1, 5'd1}},
			// zero max with one negative counter in the bank
			'{OP_CLR, 4'd15, 17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd15}},
			'{OP_CLR, 4'd7,  17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd16}},
			// climb, then one more increment gives a single top counter
			'{OP_INC, 4'd3,  17'd20,    1'b0, '0},
			'{OP_INC, 4'd3,  17'd1,     1'b1, '{16'sd21, 16'sd21, 5'd1}},
			// fall, then one more decrement
			'{OP_DEC, 4'd10, 17'd20,    1'b0, '0},
			'{OP_DEC, 4'd10, 17'd1,     1'b1, '{-16'sd21, 16'sd21, 5'd1}},
			'{OP_QRY, 4'd10, 17'd1,     1'b1, '{-16'sd21, 16'sd21, 5'd1}},
			// clear of the top counter drops the max to zero
			'{OP_CLR, 4'd3,  17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd15}},
			'{OP_DEC, 4'd3,  17'd1,     1'b1, '{-16'sd1, 16'sd0, 5'd14}},
			'{OP_INC, 4'd10, 17'd1,     1'b1, '{-16'sd20, 16'sd0, 5'd14}},
			'{OP_CLR, 4'd10, 17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd15}},
			'{OP_CLR, 4'd3,  17'd1,     1'b1, '{16'sd0, 16'sd0, 5'd16}}
		};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			calm            = (script[i].reps > 1);
			w.opcode        = script[i].op;
			w.counter_index = script[i].idx;
			repeat (script[i].reps)
				send_word(w, script[i].typed, script[i].want);
		end

		// Random traffic in stretches; about one stretch in four runs with
		// no gaps. Over half the words hit counters 0..3 so ties and long runs
		// of the same counter show up.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			seg_len = $urandom_range(40, 250);
			if (seg_len > RANDOM_WORDS - sent)
				seg_len = RANDOM_WORDS - sent;
			calm    = ($urandom_range(3) == 0);
			repeat (seg_len) begin
				r = $urandom_range(99);
				if (r < 35)
					w.opcode = OP_INC;
				else if (r < 60)
					w.opcode = OP_DEC;
				else if (r < 75)
					w.opcode = OP_CLR;
				else
					w.opcode = OP_QRY;
				if ($urandom_range(1))
					w.counter_index = IDX_W'($urandom_range(3));
				else
					w.counter_index = IDX_W'($urandom_range(NUM_COUNTERS - 1));
				send_word(w, 1'b0, '0);
				sent++;
			end
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then keep watching the output to catch stray words
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (NUM_COUNTERS + 8)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
